>>> hw/rtl/u8dec_pkg.sv
// Package with shared types and constants for the UTF-8 decoder.
package u8dec_pkg;

	// Width of the per-string character counter; wraps modulo 2**COUNT_BITS.
	localparam int COUNT_BITS = 16;
	// Width used to compare the counter against the limit register.
	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	localparam int CP_W = 27;
	localparam int IDX_W = 16;
	localparam int REM_W = 3;

	// Configuration register map (word index into the APB space).
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_MAX_CHARS = 1'b0;

	// Lead byte classification masks and match patterns.
	localparam logic [7:0] LEAD1_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT = 8'hF0;
	localparam logic [7:0] CONT_MASK = 8'h3F;
	localparam logic [7:0] PAY2_MASK = 8'h1F;
	localparam logic [7:0] PAY3_MASK = 8'h0F;
	localparam logic [7:0] PAY4_MASK = 8'h07;

	// Continuation bytes still expected after each kind of lead byte.
	localparam logic [REM_W-1:0] REM_NONE = 3'd0;
	localparam logic [REM_W-1:0] REM_TWO = 3'd1;
	localparam logic [REM_W-1:0] REM_THREE = 3'd2;
	localparam logic [REM_W-1:0] REM_FOUR = 3'd3;
	localparam logic [REM_W-1:0] REM_FIVE = 3'd4;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		logic [CP_W-1:0]       partial_value;
		logic [REM_W-1:0]      bytes_remaining;
		logic [COUNT_BITS-1:0] chars_out;
		logic                  limit_reached;
	} dec_state_t;

	// One result item.
	typedef struct packed {
		logic             char_valid;
		logic [CP_W-1:0]  code_point;
		logic [IDX_W-1:0] char_index;
		logic             string_done;
		logic [IDX_W-1:0] total_chars;
	} dec_result_t;

endpackage

>>> hw/rtl/u8dec_if.sv
// Valid/ready channel interfaces for the byte input and the character output.
interface u8dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8dec_char_if;
	logic                            valid;
	logic                            ready;
	logic                            char_valid;
	logic [u8dec_pkg::CP_W-1:0]      code_point;
	logic [u8dec_pkg::IDX_W-1:0]     char_index;
	logic                            string_done;
	logic [u8dec_pkg::IDX_W-1:0]     total_chars;

	modport source (output valid, output char_valid, output code_point, output char_index,
		output string_done, output total_chars, input ready);
	modport sink (input valid, input char_valid, input code_point, input char_index,
		input string_done, input total_chars, output ready);
endinterface

>>> hw/rtl/utf8_to_code_point_decoder_core.sv
// UTF-8 decoder top level: byte input register, decode step, result register, APB register.
//
// Decodes one UTF-8 byte per clock cycle while the output is not stalled. A taken byte sits
// in the input register, is decoded against the running state, and its result (a completed
// code point, or the end-of-string summary on the last byte) is then held in the result
// register, so a new byte can be taken every cycle while the output keeps up. The throughput
// rests on the decode step, which updates the running state, including the accumulator and
// character counter. While a result waits on the output, the input register still takes one
// byte; the input stalls only when both registers are full and the output is not being
// taken. max_chars (register 0, byte address 0) may be written only while no byte is in
// flight; zero means no limit. All string state clears after the last byte. No reset sweep
// is needed.
module utf8_to_code_point_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	u8dec_byte_if.sink                      bytes,
	u8dec_char_if.source                    chars,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [u8dec_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   valid_s2;
	u8dec_pkg::dec_result_t res_s2;
	u8dec_pkg::dec_state_t  state_q;
	logic [15:0]            max_chars_q;
	u8dec_pkg::dec_state_t  state_nxt;
	u8dec_pkg::dec_result_t res_nxt;
	logic                   emit;
	logic                   out_free;
	logic                   advance;
	logic                   cfg_wr;

	// Configuration register write and read.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == u8dec_pkg::REG_MAX_CHARS);
	assign prdata = (paddr[2] == u8dec_pkg::REG_MAX_CHARS) ? {16'd0, max_chars_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= '0;
		end else if (cfg_wr) begin
			max_chars_q <= pwdata[15:0];
		end
	end

	// Flow control: the decode stage moves when the result register can take a result.
	assign out_free = !valid_s2 || chars.ready;
	assign advance = valid_s1 && out_free;
	assign bytes.ready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.byte_in;
			last_s1 <= bytes.last_byte;
		end
	end

	u8dec_step u_step (
		.cur       (state_q),
		.max_chars (max_chars_q),
		.byte_in   (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt),
		.emit      (emit)
	);

	// Decoder state; everything returns to zero after the last byte of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= last_s1 ? '0 : state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= res_nxt;
		end
	end

	assign chars.valid = valid_s2;
	assign chars.char_valid = res_s2.char_valid;
	assign chars.code_point = res_s2.code_point;
	assign chars.char_index = res_s2.char_index;
	assign chars.string_done = res_s2.string_done;
	assign chars.total_chars = res_s2.total_chars;

	// A processed last byte leaves the decoder in its start-of-string state.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.bytes_remaining == u8dec_pkg::REM_NONE &&
			state_q.chars_out == '0 && !state_q.limit_reached)
		else $error("decoder state not cleared after last byte");

	// At most four continuation bytes are ever outstanding.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_remaining <= u8dec_pkg::REM_FIVE)
		else $error("continuation count out of range");

	// The limit is only noticed between characters.
	a_limit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.limit_reached |-> state_q.bytes_remaining == u8dec_pkg::REM_NONE)
		else $error("limit reached inside a sequence");

	// A result without a character is only the end-of-string summary.
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.char_valid |-> res_s2.string_done)
		else $error("empty result without string end");

	// A byte waiting on a full result register is not lost.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input byte changed");

endmodule

>>> hw/rtl/u8dec_step.sv
// Combinational decode of one byte against the current decoder state.
module u8dec_step (
	input  u8dec_pkg::dec_state_t  cur,
	input  logic [15:0]            max_chars,
	input  logic [7:0]             byte_in,
	input  logic                   last_byte,
	output u8dec_pkg::dec_state_t  nxt,
	output u8dec_pkg::dec_result_t res,
	output logic                   emit
);

	logic                                got;
	logic [u8dec_pkg::CP_W-1:0]          cp;
	logic [u8dec_pkg::CP_W-1:0]          shifted;
	logic [u8dec_pkg::REM_W-1:0]         rem_dec;
	logic                                at_limit;

	// The limit applies only when it is nonzero and the count has reached it.
	assign at_limit = (max_chars != 16'd0) &&
		(u8dec_pkg::CMP_W'(cur.chars_out) >= u8dec_pkg::CMP_W'(max_chars));
	assign shifted = {cur.partial_value[u8dec_pkg::CP_W-7:0], byte_in[5:0]};
	assign rem_dec = cur.bytes_remaining - 3'd1;

	// Classify lead bytes and fold continuation bytes into the accumulator.
	always_comb begin
		nxt = cur;
		got = 1'b0;
		cp = '0;
		if (!cur.limit_reached) begin
			if (cur.bytes_remaining == u8dec_pkg::REM_NONE) begin
				if (at_limit) begin
					nxt.limit_reached = 1'b1;
				end else if ((byte_in & u8dec_pkg::LEAD1_MASK) == 8'h00) begin
					cp = u8dec_pkg::CP_W'(byte_in);
					got = 1'b1;
				end else if ((byte_in & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_PAT) begin
					nxt.partial_value = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::PAY2_MASK);
					nxt.bytes_remaining = u8dec_pkg::REM_TWO;
				end else if ((byte_in & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_PAT) begin
					nxt.partial_value = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::PAY3_MASK);
					nxt.bytes_remaining = u8dec_pkg::REM_THREE;
				end else if ((byte_in & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_PAT) begin
					nxt.partial_value = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::PAY4_MASK);
					nxt.bytes_remaining = u8dec_pkg::REM_FOUR;
				end else begin
					nxt.partial_value = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::PAY4_MASK);
					nxt.bytes_remaining = u8dec_pkg::REM_FIVE;
				end
			end else begin
				nxt.bytes_remaining = rem_dec;
				nxt.partial_value = shifted;
				if (rem_dec == u8dec_pkg::REM_NONE) begin
					cp = shifted;
					nxt.partial_value = '0;
					got = 1'b1;
				end
			end
		end
		if (got) begin
			nxt.chars_out = cur.chars_out + u8dec_pkg::COUNT_BITS'(1);
		end
	end

	// Build the result item; the index is the count before this character.
	always_comb begin
		res.char_valid = got;
		res.code_point = cp;
		res.char_index = got ? u8dec_pkg::IDX_W'(cur.chars_out) : '0;
		res.string_done = last_byte;
		res.total_chars = u8dec_pkg::IDX_W'(nxt.chars_out);
	end

	assign emit = got || last_byte;

endmodule
